// ===== rtl/sfp_pkg.sv =====
// Shared types and constants of the synthesizer frequency plan.
// Holds the request and result structs, path and register codes, and the
// fixed frequencies and reciprocals that the pipeline uses. No dependencies.
`default_nettype none

package sfp_pkg;

  typedef struct packed {
    logic        operation;
    logic [31:0] output_hz;
  } req_t;

  typedef struct packed {
    logic        plan_valid;
    logic [2:0]  path_code;
    logic [29:0] oscillator_hz;
    logic [26:0] point_a_hz;
    logic [31:0] point_b_numerator_hz;
    logic [22:0] delta_hz;
    logic [6:0]  step_divisor;
    logic [7:0]  reg4_value;
    logic [7:0]  reg5_value;
    logic [7:0]  reg12_range_bits;
    logic [6:0]  reg13_low_bits;
  } rsp_t;

  // Operation codes.
  localparam logic OP_BASE    = 1'b0;
  localparam logic OP_DOUBLER = 1'b1;

  // Path codes.
  localparam logic [2:0] PATH_HET_LOW   = 3'd0;
  localparam logic [2:0] PATH_HET       = 3'd1;
  localparam logic [2:0] PATH_DIV2_O2   = 3'd2;
  localparam logic [2:0] PATH_DIV2_O1   = 3'd3;
  localparam logic [2:0] PATH_DIRECT_O2 = 3'd4;
  localparam logic [2:0] PATH_DIRECT_O1 = 3'd5;
  localparam logic [2:0] PATH_DBL_O2    = 3'd6;
  localparam logic [2:0] PATH_DBL_O1    = 3'd7;

  // Path control bytes for register address 5.
  localparam logic [7:0] R5_HET_LOW   = 8'h23;
  localparam logic [7:0] R5_HET       = 8'h03;
  localparam logic [7:0] R5_DIV2_O2   = 8'h04;
  localparam logic [7:0] R5_DIV2_O1   = 8'h05;
  localparam logic [7:0] R5_DIRECT_O2 = 8'h08;
  localparam logic [7:0] R5_DIRECT_O1 = 8'h09;
  localparam logic [7:0] R5_DBL_O2    = 8'h10;
  localparam logic [7:0] R5_DBL_O1    = 8'h11;

  // Range bits for register address 12.
  localparam logic [7:0] R12_HET    = 8'h84;
  localparam logic [7:0] R12_DIV2   = 8'h00;
  localparam logic [7:0] R12_DIRECT = 8'h04;
  localparam logic [7:0] R12_DBL    = 8'h02;

  // Request limits and path boundaries.
  localparam logic [31:0] BASE_MIN_HZ      = 32'd100_000;
  localparam logic [31:0] BASE_MAX_HZ      = 32'd560_000_000;
  localparam logic [31:0] DBL_MIN_HZ       = 32'd560_000_000;
  localparam logic [31:0] DBL_LIMIT_HZ     = 32'd1_120_000_000;
  localparam logic [31:0] HET_LOW_LIMIT_HZ = 32'd1_500_000;
  localparam logic [31:0] HET_LIMIT_HZ     = 32'd122_000_000;
  localparam logic [31:0] DIV2_O2_LIMIT_HZ = 32'd184_000_000;
  localparam logic [31:0] DIV2_O1_LIMIT_HZ = 32'd280_000_000;
  localparam logic [31:0] DIR_O2_LIMIT_HZ  = 32'd368_000_000;
  localparam logic [31:0] DBL_O2_LIMIT_HZ  = 32'd736_000_000;

  localparam logic [29:0] HET_OFFSET_HZ = 30'd400_000_000;
  localparam logic [29:0] OFFSET_HZ     = 30'd18_000_000;
  localparam logic [29:0] STEP_HZ       = 30'd8_000_000;
  localparam logic [31:0] B_STEP_HZ     = 32'd40_000_000;
  localparam logic [26:0] PA_BASE_HZ    = 27'd90_000_000;
  // Point A stays at or below 129999975 Hz exactly when delta does not exceed this.
  localparam logic [22:0] DELTA_MAX_HZ  = 23'd7_999_995;

  localparam logic [6:0] DIV_MIN = 7'd28;
  localparam logic [6:0] DIV_MAX = 7'd67;

  // 8 MHz = 15625 << 9 and 1 MHz = 15625 << 6, so both divisions share the odd factor.
  localparam int unsigned   STEP_SHIFT  = 9;
  localparam int unsigned   MHZ_SHIFT   = 6;
  localparam int unsigned   RECIP_SHIFT = 32;
  localparam logic [13:0]   ODD_FACTOR  = 14'd15625;
  // ceil(2^32 / 15625): exact quotient for any 21-bit dividend.
  localparam logic [18:0]   STEP_RECIP  = 19'd274878;
  // floor(2^32 / 15625): quotient low by at most one, fixed by one compare.
  localparam logic [18:0]   MHZ_RECIP   = 19'd274877;

  localparam int unsigned TRK_BIT = 7;

endpackage

`default_nettype wire

// ===== rtl/synthesizer_frequency_plan.sv =====
// Synthesizer frequency plan: five-stage pipeline from a requested output
// frequency to path, oscillator frequency, step split and register codes.
// Depends on sfp_pkg for the request and result structs and all constants.
//
// Use: a request (req, req_valid) is taken at a rising edge where req_valid
// is high and req_stall is low. Each request gives exactly one result on
// rsp, with rsp_valid high until the receiver takes it (rsp_stall low).
// A request that is out of range, not step aligned or fails the divisor or
// point A checks returns plan_valid low with every other field zero.
// The request passes registers s1 to s4 and rsp on its way to the result.
// Throughput: one request per cycle unless a result stalls; the longest
// stage is the first, with the 25 x 19 bit reciprocal multiply that
// estimates the request in whole MHz. When the receiver stalls a waiting
// result, the whole pipeline holds and req_stall rises in the same cycle;
// nothing is dropped or repeated. Reset (rst, synchronous) clears every
// stage valid bit; the block takes a request in the first cycle after reset.
`default_nettype none

module synthesizer_frequency_plan (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sfp_pkg::req_t req,
  input  wire logic          req_valid,
  output logic               req_stall,
  output sfp_pkg::rsp_t      rsp,
  output logic               rsp_valid,
  input  wire logic          rsp_stall
);

  logic adv;

  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  // ---------------------------------------------------------------- stage 1
  logic [6:0]  nib_sum;
  logic [4:0]  nib_fold;
  logic        mult5;
  logic        ok_1;
  logic [2:0]  path_1;
  logic [7:0]  r5_1;
  logic [7:0]  r12_1;
  logic [29:0] osc_1;
  logic [24:0] mhz_x_1;
  logic [43:0] mhz_prod;

  logic        s1_valid;
  logic        s1_ok;
  logic        s1_op;
  logic [2:0]  s1_path;
  logic [7:0]  s1_r5;
  logic [7:0]  s1_r12;
  logic [29:0] s1_osc;
  logic [11:0] s1_mhz_q;
  logic [24:0] s1_mhz_x;

  // 16 is 1 modulo 5, so the nibble sum keeps the remainder by 5.
  always_comb begin
    nib_sum = '0;
    for (int i = 0; i < 8; i++) begin
      nib_sum = nib_sum + 7'(req.output_hz[4*i +: 4]);
    end
    nib_fold = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
    mult5    = nib_fold inside {5'd0, 5'd5, 5'd10, 5'd15, 5'd20};
  end

  always_comb begin
    ok_1   = 1'b0;
    path_1 = sfp_pkg::PATH_DIRECT_O1;
    r5_1   = sfp_pkg::R5_DIRECT_O1;
    r12_1  = sfp_pkg::R12_DIRECT;
    osc_1  = req.output_hz[29:0];
    if (req.operation == sfp_pkg::OP_BASE) begin
      ok_1 = req.output_hz >= sfp_pkg::BASE_MIN_HZ &&
             req.output_hz <= sfp_pkg::BASE_MAX_HZ && mult5;
      if (req.output_hz < sfp_pkg::HET_LIMIT_HZ) begin
        osc_1 = sfp_pkg::HET_OFFSET_HZ + req.output_hz[29:0];
        r12_1 = sfp_pkg::R12_HET;
        if (req.output_hz < sfp_pkg::HET_LOW_LIMIT_HZ) begin
          path_1 = sfp_pkg::PATH_HET_LOW;
          r5_1   = sfp_pkg::R5_HET_LOW;
        end else begin
          path_1 = sfp_pkg::PATH_HET;
          r5_1   = sfp_pkg::R5_HET;
        end
      end else if (req.output_hz < sfp_pkg::DIV2_O2_LIMIT_HZ) begin
        osc_1  = {req.output_hz[28:0], 1'b0};
        path_1 = sfp_pkg::PATH_DIV2_O2;
        r5_1   = sfp_pkg::R5_DIV2_O2;
        r12_1  = sfp_pkg::R12_DIV2;
      end else if (req.output_hz < sfp_pkg::DIV2_O1_LIMIT_HZ) begin
        osc_1  = {req.output_hz[28:0], 1'b0};
        path_1 = sfp_pkg::PATH_DIV2_O1;
        r5_1   = sfp_pkg::R5_DIV2_O1;
        r12_1  = sfp_pkg::R12_DIV2;
      end else if (req.output_hz < sfp_pkg::DIR_O2_LIMIT_HZ) begin
        path_1 = sfp_pkg::PATH_DIRECT_O2;
        r5_1   = sfp_pkg::R5_DIRECT_O2;
      end
    end else begin
      ok_1  = req.output_hz >= sfp_pkg::DBL_MIN_HZ &&
              req.output_hz < sfp_pkg::DBL_LIMIT_HZ && mult5 && !req.output_hz[0];
      osc_1 = req.output_hz[30:1];
      r12_1 = sfp_pkg::R12_DBL;
      if (req.output_hz < sfp_pkg::DBL_O2_LIMIT_HZ) begin
        path_1 = sfp_pkg::PATH_DBL_O2;
        r5_1   = sfp_pkg::R5_DBL_O2;
      end else begin
        path_1 = sfp_pkg::PATH_DBL_O1;
        r5_1   = sfp_pkg::R5_DBL_O1;
      end
    end
  end

  // Estimate of the request in whole MHz, for the tracking decision.
  assign mhz_x_1  = req.output_hz[30:sfp_pkg::MHZ_SHIFT];
  assign mhz_prod = 44'(mhz_x_1) * 44'(sfp_pkg::MHZ_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ok    <= ok_1;
      s1_op    <= req.operation;
      s1_path  <= path_1;
      s1_r5    <= r5_1;
      s1_r12   <= r12_1;
      s1_osc   <= osc_1;
      s1_mhz_q <= mhz_prod[43:sfp_pkg::RECIP_SHIFT];
      s1_mhz_x <= mhz_x_1;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [26:0] mhz_back;
  logic [26:0] mhz_rem;
  logic [11:0] mhz_2;

  logic        s2_valid;
  logic        s2_ok;
  logic        s2_op;
  logic [2:0]  s2_path;
  logic [7:0]  s2_r5;
  logic [7:0]  s2_r12;
  logic [29:0] s2_osc;
  logic [29:0] s2_shifted;
  logic [10:0] s2_mhz;

  assign mhz_back = 27'(s1_mhz_q) * 27'(sfp_pkg::ODD_FACTOR);
  assign mhz_rem  = 27'(s1_mhz_x) - mhz_back;
  assign mhz_2    = (mhz_rem >= 27'(sfp_pkg::ODD_FACTOR)) ? s1_mhz_q + 12'd1 : s1_mhz_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ok      <= s1_ok && s1_osc >= sfp_pkg::OFFSET_HZ;
      s2_op      <= s1_op;
      s2_path    <= s1_path;
      s2_r5      <= s1_r5;
      s2_r12     <= s1_r12;
      s2_osc     <= s1_osc;
      s2_shifted <= s1_osc - sfp_pkg::OFFSET_HZ;
      s2_mhz     <= mhz_2[10:0];
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [39:0] step_prod;
  logic [3:0]  hund_3;
  logic [10:0] hund_base;
  logic [10:0] lo_full;

  logic        s3_valid;
  logic        s3_ok;
  logic        s3_op;
  logic [2:0]  s3_path;
  logic [7:0]  s3_r5;
  logic [7:0]  s3_r12;
  logic [29:0] s3_osc;
  logic [29:0] s3_shifted;
  logic [7:0]  s3_div;
  logic [3:0]  s3_hund;
  logic [6:0]  s3_lo;

  assign step_prod = 40'(s2_shifted[29:sfp_pkg::STEP_SHIFT]) * 40'(sfp_pkg::STEP_RECIP);

  // Hundreds-of-MHz digit as the BCD decision sees it: after the 0x0A
  // correction, 10 and 11 act as 6 and 7.
  always_comb begin
    if (s2_mhz >= 11'd1100) begin
      hund_3 = 4'd7;  hund_base = 11'd1100;
    end else if (s2_mhz >= 11'd1000) begin
      hund_3 = 4'd6;  hund_base = 11'd1000;
    end else if (s2_mhz >= 11'd900) begin
      hund_3 = 4'd9;  hund_base = 11'd900;
    end else if (s2_mhz >= 11'd800) begin
      hund_3 = 4'd8;  hund_base = 11'd800;
    end else if (s2_mhz >= 11'd700) begin
      hund_3 = 4'd7;  hund_base = 11'd700;
    end else if (s2_mhz >= 11'd600) begin
      hund_3 = 4'd6;  hund_base = 11'd600;
    end else begin
      hund_3 = 4'd5;  hund_base = 11'd500;
    end
    lo_full = s2_mhz - hund_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ok      <= s2_ok;
      s3_op      <= s2_op;
      s3_path    <= s2_path;
      s3_r5      <= s2_r5;
      s3_r12     <= s2_r12;
      s3_osc     <= s2_osc;
      s3_shifted <= s2_shifted;
      s3_div     <= step_prod[39:sfp_pkg::RECIP_SHIFT];
      s3_hund    <= hund_3;
      s3_lo      <= lo_full[6:0];
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [29:0] delta_full;
  logic        trk_4;
  logic        ok_4;

  logic        s4_valid;
  logic        s4_ok;
  logic [2:0]  s4_path;
  logic [7:0]  s4_r5;
  logic [7:0]  s4_r12;
  logic [29:0] s4_osc;
  logic [22:0] s4_delta;
  logic [6:0]  s4_div;
  logic        s4_trk;
  logic [31:0] s4_b_off;

  assign delta_full = s3_shifted - 30'(s3_div) * sfp_pkg::STEP_HZ;

  // Comparing the two-digit MHz remainder in decimal orders it the same as its BCD byte.
  always_comb begin
    if (s3_op == sfp_pkg::OP_BASE) begin
      trk_4 = 1'b1;
    end else if (s3_hund == 4'd5) begin
      trk_4 = 1'b1;
    end else if (s3_hund >= 4'd9) begin
      trk_4 = s3_lo >= 7'd64 || s3_lo < 7'd24;
    end else if (s3_hund >= 4'd8) begin
      trk_4 = s3_lo >= 7'd84 || (s3_lo >= 7'd4 && s3_lo < 7'd44);
    end else if (s3_hund >= 4'd7) begin
      trk_4 = s3_lo >= 7'd24 && s3_lo < 7'd64;
    end else begin
      trk_4 = (s3_lo >= 7'd44 && s3_lo < 7'd84) || s3_lo < 7'd4;
    end
  end

  assign ok_4 = s3_ok && s3_div >= 8'(sfp_pkg::DIV_MIN) && s3_div <= 8'(sfp_pkg::DIV_MAX) &&
                delta_full <= 30'(sfp_pkg::DELTA_MAX_HZ);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ok    <= ok_4;
      s4_path  <= s3_path;
      s4_r5    <= s3_r5;
      s4_r12   <= s3_r12;
      s4_osc   <= s3_osc;
      s4_delta <= delta_full[22:0];
      s4_div   <= s3_div[6:0];
      s4_trk   <= trk_4;
      s4_b_off <= 32'(s3_div[6:0]) * sfp_pkg::B_STEP_HZ;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic [26:0] pa_5;
  logic [31:0] pb_5;
  logic [13:0] q5_prod;
  logic [3:0]  q5;
  logic [6:0]  r5_mod;
  logic [4:0]  code_hi;
  logic [6:0]  code_5;
  sfp_pkg::rsp_t rsp_next;

  assign pa_5    = sfp_pkg::PA_BASE_HZ + 27'({s4_delta, 2'b00}) + 27'(s4_delta);
  assign pb_5    = 32'(pa_5) + s4_b_off;
  // x * 205 >> 10 is the exact quotient by 5 for divisors up to 79, which covers DIV_MIN to DIV_MAX.
  assign q5_prod = 14'(s4_div) * 14'd205;
  assign q5      = q5_prod[13:10];
  assign r5_mod  = s4_div - 7'(q5) * 7'd5;
  assign code_hi = 5'd16 - 5'(q5);
  assign code_5  = {code_hi[3:0], r5_mod[2:0]};

  always_comb begin
    rsp_next = '0;
    if (s4_ok) begin
      rsp_next.plan_valid           = 1'b1;
      rsp_next.path_code            = s4_path;
      rsp_next.oscillator_hz        = s4_osc;
      rsp_next.point_a_hz           = pa_5;
      rsp_next.point_b_numerator_hz = pb_5;
      rsp_next.delta_hz             = s4_delta;
      rsp_next.step_divisor         = s4_div;
      rsp_next.reg4_value           = {s4_trk, code_5};
      rsp_next.reg5_value           = s4_r5;
      rsp_next.reg12_range_bits     = s4_r12;
      rsp_next.reg13_low_bits       = code_5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_next;
    end
  end

  // ------------------------------------------------------------- assertions
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !s1_valid && !s4_valid)
    else $error("pipeline not empty after reset");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(s1_valid) && $stable(s2_valid) &&
                               $stable(s3_valid) && $stable(s4_valid))
    else $error("pipeline moved while the result was stalled");

  a_code_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.plan_valid |->
      rsp.reg13_low_bits == rsp.reg4_value[sfp_pkg::TRK_BIT-1:0] &&
      rsp.reg4_value[sfp_pkg::TRK_BIT] == 1'b1 || rsp.path_code == sfp_pkg::PATH_DBL_O2 ||
      rsp.path_code == sfp_pkg::PATH_DBL_O1)
    else $error("register codes disagree");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.plan_valid |->
      rsp.step_divisor >= sfp_pkg::DIV_MIN && rsp.step_divisor <= sfp_pkg::DIV_MAX)
    else $error("accepted plan with divisor out of range");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.plan_valid |->
      rsp.oscillator_hz == '0 && rsp.path_code == '0 && rsp.reg5_value == '0 &&
      rsp.point_b_numerator_hz == '0)
    else $error("rejected plan carries nonzero fields");

endmodule

`default_nettype wire

// ===== verif/synthesizer_frequency_plan_tb.sv =====
// Self-checking testbench for the synthesizer frequency plan block.
// Drives a directed table of requests and then random ones, and checks every result against
// its typed expectation or plan predictor. Depends on sfp_pkg and the synthesizer_frequency_plan RTL.
module synthesizer_frequency_plan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfp_pkg::*;

  localparam int unsigned RANDOM_REQUESTS  = 900;
  localparam int unsigned LONG_HOLD_CYCLES = 80;
  localparam int unsigned POINT_A_CEIL_HZ  = 129_999_975;
  localparam rsp_t        NO_PLAN          = '0;

  typedef struct {
    req_t request;
    bit   typed;
    rsp_t result;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  req_t req = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall = 1'b0;

  // Typed expectation that travels alongside the request being offered.
  logic drv_typed = 1'b0;
  rsp_t drv_plan = '0;

  rsp_t        plans_due[$];
  plan_row_t   plan_rows[$];
  int unsigned mismatches = 0;
  int unsigned requests_taken = 0;
  int unsigned plans_granted = 0;
  int unsigned plans_refused = 0;
  int unsigned input_stall_cycles = 0;
  logic [7:0]  paths_seen = '0;
  bit          rx_quiet = 1'b0;
  bit          hold_wanted = 1'b0;

  synthesizer_frequency_plan uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] bcd_byte(input int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // Doubler tracking decision on the BCD hundreds digit and the BCD MHz pair below it.
  function automatic bit doubler_track_high(input int unsigned f);
    logic [7:0] hundreds;
    logic [7:0] mhz;
    hundreds = bcd_byte(f / 100_000_000);
    mhz = bcd_byte((f / 1_000_000) % 100);
    // Hundreds digits of ten and eleven fold back onto six and seven.
    if (hundreds >= 8'h10) hundreds = hundreds - 8'h0A;
    if (hundreds == 8'h05) return 1'b1;
    if (hundreds >= 8'h09) return mhz >= 8'h64 || mhz < 8'h24;
    if (hundreds >= 8'h08) return mhz >= 8'h84 || (mhz >= 8'h04 && mhz < 8'h44);
    if (hundreds >= 8'h07) return mhz >= 8'h24 && mhz < 8'h64;
    return (mhz >= 8'h44 && mhz < 8'h84) || mhz < 8'h04;
  endfunction

  function automatic rsp_t plan_for(input req_t r);
    rsp_t        p;
    int unsigned f;
    int unsigned osc;
    int unsigned shifted;
    int unsigned div;
    int unsigned delta;
    int unsigned pa;
    logic [6:0]  code;
    logic [2:0]  path;
    logic [7:0]  r5;
    logic [7:0]  r12;
    bit          trk;
    p = NO_PLAN;
    f = r.output_hz;
    if (r.operation == OP_BASE) begin
      if (f < BASE_MIN_HZ || f > BASE_MAX_HZ || f % 5 != 0) return p;
      trk = 1'b1;
      osc = f;
      path = PATH_DIRECT_O1;
      r5 = R5_DIRECT_O1;
      r12 = R12_DIRECT;
      if (f < HET_LIMIT_HZ) begin
        osc = HET_OFFSET_HZ + f;
        path = (f < HET_LOW_LIMIT_HZ) ? PATH_HET_LOW : PATH_HET;
        r5 = (f < HET_LOW_LIMIT_HZ) ? R5_HET_LOW : R5_HET;
        r12 = R12_HET;
      end else if (f < DIV2_O2_LIMIT_HZ) begin
        osc = 2 * f;
        path = PATH_DIV2_O2;
        r5 = R5_DIV2_O2;
        r12 = R12_DIV2;
      end else if (f < DIV2_O1_LIMIT_HZ) begin
        osc = 2 * f;
        path = PATH_DIV2_O1;
        r5 = R5_DIV2_O1;
        r12 = R12_DIV2;
      end else if (f < DIR_O2_LIMIT_HZ) begin
        path = PATH_DIRECT_O2;
        r5 = R5_DIRECT_O2;
      end
    end else begin
      if (f < DBL_MIN_HZ || f >= DBL_LIMIT_HZ || f % 10 != 0) return p;
      osc = f / 2;
      path = (f < DBL_O2_LIMIT_HZ) ? PATH_DBL_O2 : PATH_DBL_O1;
      r5 = (f < DBL_O2_LIMIT_HZ) ? R5_DBL_O2 : R5_DBL_O1;
      r12 = R12_DBL;
      trk = doubler_track_high(f);
    end
    if (osc < OFFSET_HZ) return p;
    shifted = osc - OFFSET_HZ;
    div = shifted / STEP_HZ;
    delta = shifted % STEP_HZ;
    pa = 5 * (OFFSET_HZ + delta);
    if (div < DIV_MIN || div > DIV_MAX || pa < PA_BASE_HZ || pa > POINT_A_CEIL_HZ) return p;
    code = 7'(((16 - div / 5) << 3) | (div % 5));
    p.plan_valid = 1'b1;
    p.path_code = path;
    p.oscillator_hz = 30'(osc);
    p.point_a_hz = 27'(pa);
    p.point_b_numerator_hz = pa + div * B_STEP_HZ;
    p.delta_hz = 23'(delta);
    p.step_divisor = 7'(div);
    p.reg4_value = {trk, code};
    p.reg5_value = r5;
    p.reg12_range_bits = r12;
    p.reg13_low_bits = code;
    return p;
  endfunction

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_row(input logic op, input logic [31:0] hz, input bit typed,
                         input rsp_t want);
    plan_row_t row;
    row.request.operation = op;
    row.request.output_hz = hz;
    row.typed = typed;
    row.result = want;
    plan_rows.push_back(row);
  endtask

  task automatic send_request(input req_t r, input bit typed, input rsp_t want,
                              input bit quiet);
    int unsigned gap;
    gap = pick_gap(quiet);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    drv_typed <= typed;
    drv_plan <= want;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // Scoreboard: record accepted requests and check accepted results in order.
  always @(posedge clk) begin : scoreboard
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_stall) input_stall_cycles++;
      if (req_valid && !req_stall) begin
        plans_due.push_back(drv_typed ? drv_plan : plan_for(req));
        requests_taken++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (plans_due.size() == 0) begin
          $error("result with no request outstanding: 0x%0h", rsp);
          mismatches++;
        end else begin
          want = plans_due.pop_front();
          if (want.plan_valid) begin
            plans_granted++;
            paths_seen[want.path_code] = 1'b1;
          end else begin
            plans_refused++;
          end
          check_field("plan_valid", want.plan_valid, rsp.plan_valid);
          check_field("path_code", want.path_code, rsp.path_code);
          check_field("oscillator_hz", want.oscillator_hz, rsp.oscillator_hz);
          check_field("point_a_hz", want.point_a_hz, rsp.point_a_hz);
          check_field("point_b_numerator_hz", want.point_b_numerator_hz,
                      rsp.point_b_numerator_hz);
          check_field("delta_hz", want.delta_hz, rsp.delta_hz);
          check_field("step_divisor", want.step_divisor, rsp.step_divisor);
          check_field("reg4_value", want.reg4_value, rsp.reg4_value);
          check_field("reg5_value", want.reg5_value, rsp.reg5_value);
          check_field("reg12_range_bits", want.reg12_range_bits, rsp.reg12_range_bits);
          check_field("reg13_low_bits", want.reg13_low_bits, rsp.reg13_low_bits);
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold that the stimulus asks for.
  initial begin : receiver
    int unsigned len;
    forever begin
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        len = pick_gap(rx_quiet);
        rsp_stall <= (len != 0);
        repeat ((len == 0) ? 1 : len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] edges[16];
    req_t        r;
    int unsigned roll;
    int          offset;
    bit          quiet;
    edges = '{BASE_MIN_HZ, HET_LOW_LIMIT_HZ, HET_LIMIT_HZ, DIV2_O2_LIMIT_HZ,
              DIV2_O1_LIMIT_HZ, DIR_O2_LIMIT_HZ, BASE_MAX_HZ, DBL_O2_LIMIT_HZ,
              DBL_LIMIT_HZ, 32'd600_000_000, 32'd700_000_000, 32'd800_000_000,
              32'd900_000_000, 32'd1_000_000_000, 32'd1_100_000_000, 32'd0};

    // Rejections and the lowest heterodyne plan are typed in; the rest are predicted.
    add_row(OP_BASE, 32'd0, 1'b1, NO_PLAN);
    add_row(OP_BASE, 32'd99_995, 1'b1, NO_PLAN);
    add_row(OP_BASE, 32'd100_000, 1'b1,
            {1'b1, PATH_HET_LOW, 30'd400_100_000, 27'd120_500_000, 32'd2_000_500_000,
             23'd6_100_000, 7'd47, 8'hBA, R5_HET_LOW, R12_HET, 7'h3A});
    add_row(OP_BASE, 32'd100_001, 1'b1, NO_PLAN);
    add_row(OP_BASE, 32'd1_499_995, 1'b0, NO_PLAN);
    add_row(OP_BASE, 32'd1_500_000, 1'b0, NO_PLAN);
    add_row(OP_BASE, 32'd121_999_995, 1'b0, NO_PLAN);
    add_row(OP_BASE, 32'd122_000_000, 1'b0, NO_PLAN);
    add_row(OP_BASE, 32'd183_999_995, 1'b0, NO_PLAN);
    add_row(OP_BASE, 32'd184_000_000, 1'b0, NO_PLAN);
    add_row(OP_BASE, 32'd279_999_995, 1'b0, NO_PLAN);
    add_row(OP_BASE, 32'd280_000_000, 1'b0, NO_PLAN);
    // Largest remainder that still keeps point A in range.
    add_row(OP_BASE, 32'd345_999_995, 1'b0, NO_PLAN);
    add_row(OP_BASE, 32'd368_000_000, 1'b0, NO_PLAN);
    add_row(OP_BASE, 32'd560_000_000, 1'b0, NO_PLAN);
    add_row(OP_BASE, 32'd560_000_005, 1'b1, NO_PLAN);
    add_row(OP_BASE, 32'hFFFF_FFFF, 1'b1, NO_PLAN);
    add_row(OP_DOUBLER, 32'd559_999_990, 1'b1, NO_PLAN);
    add_row(OP_DOUBLER, 32'd560_000_000, 1'b0, NO_PLAN);
    add_row(OP_DOUBLER, 32'd735_999_990, 1'b0, NO_PLAN);
    add_row(OP_DOUBLER, 32'd736_000_000, 1'b0, NO_PLAN);
    // Hundreds digits of ten and eleven take the folded BCD path.
    add_row(OP_DOUBLER, 32'd1_000_000_000, 1'b0, NO_PLAN);
    add_row(OP_DOUBLER, 32'd1_119_999_990, 1'b0, NO_PLAN);
    add_row(OP_DOUBLER, 32'd1_120_000_000, 1'b1, NO_PLAN);
    add_row(OP_DOUBLER, 32'd900_000_005, 1'b1, NO_PLAN);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_rows[i])
      send_request(plan_rows[i].request, plan_rows[i].typed, plan_rows[i].result, 1'b0);

    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      // Two back-to-back stretches for requests, one for results, and one long result hold.
      quiet = (n >= 200 && n < 300) || (n >= 340 && n < 420);
      rx_quiet = (n >= 500 && n < 600);
      if (n == 350) hold_wanted = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        r.operation = OP_BASE;
        r.output_hz = 5 * $urandom_range(20_000, 112_000_000);
      end else if (roll < 45) begin
        r.operation = OP_BASE;
        r.output_hz = 5 * $urandom_range(20_000, 299_999);
      end else if (roll < 70) begin
        r.operation = OP_DOUBLER;
        r.output_hz = 10 * $urandom_range(56_000_000, 111_999_999);
      end else if (roll < 82) begin
        offset = int'($urandom_range(0, 40)) - 20;
        r.operation = ($urandom_range(0, 1) == 0) ? OP_BASE : OP_DOUBLER;
        r.output_hz = edges[$urandom_range(0, 15)] + offset;
      end else begin
        r.operation = ($urandom_range(0, 1) == 0) ? OP_BASE : OP_DOUBLER;
        r.output_hz = $urandom();
      end
      send_request(r, 1'b0, NO_PLAN, quiet);
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (plans_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d requests: %0d plans granted, %0d refused, paths seen %b.",
             requests_taken, plans_granted, plans_refused, paths_seen);
    $display("Input side was held off for %0d cycles under result back-pressure.",
             input_stall_cycles);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
